>>> hw/rtl/hsl_pkg.sv
// Shared constants and helpers for the HSL lightness set unit.
// Used by hsl_front, hsl_div_pipe, hsl_back and hsl_lightness_set_unit.
package hsl_pkg;

  // Pixel channel and hue widths
  localparam int unsigned CH_W   = 8;
  localparam int unsigned CH_N   = 3;
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned NUM_W  = 17;
  localparam int unsigned DEG_W  = 10;
  localparam int unsigned K_W    = 6;

  // Lightness register: 16 fraction bits, 65536 is 1.0
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_FRAC = 16;
  localparam logic [CFG_W-1:0] CFG_ONE   = 17'd65536;
  localparam logic [CFG_W-1:0] CFG_RESET = 17'd32768;

  // Hue offsets and ramp limits in degrees
  localparam logic [DEG_W-1:0] DEG_60  = 10'd60;
  localparam logic [DEG_W-1:0] DEG_120 = 10'd120;
  localparam logic [DEG_W-1:0] DEG_180 = 10'd180;
  localparam logic [DEG_W-1:0] DEG_240 = 10'd240;
  localparam logic [DEG_W-1:0] DEG_360 = 10'd360;
  localparam logic [K_W-1:0]   K_FULL  = 6'd60;
  localparam logic [K_W-1:0]   K_NONE  = 6'd0;

  // Ramp position (0..60 sixtieths) for one channel from its shifted hue
  function automatic logic [K_W-1:0] ramp_k(input logic [DEG_W-1:0] deg);
    logic [DEG_W-1:0] dn;
    logic [DEG_W-1:0] down;
    logic [K_W-1:0]   k;
    dn   = (deg > DEG_360) ? deg - DEG_360 : deg;
    down = DEG_240 - dn;
    if (dn < DEG_60) begin
      k = dn[K_W-1:0];
    end else if (dn < DEG_180) begin
      k = K_FULL;
    end else if (dn < DEG_240) begin
      k = down[K_W-1:0];
    end else begin
      k = K_NONE;
    end
    return k;
  endfunction

endpackage

>>> hw/rtl/hsl_front.sv
// Input stage: max/min of the pixel, saturation divisor and hue dividend.
// Depends on hsl_pkg.
module hsl_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           valid_i,
  input  logic [hsl_pkg::CH_W-1:0]       red_i,
  input  logic [hsl_pkg::CH_W-1:0]       green_i,
  input  logic [hsl_pkg::CH_W-1:0]       blue_i,
  output logic                           valid_o,
  output logic                           grey_o,
  output logic [hsl_pkg::CH_W-1:0]       delta_o,
  output logic [hsl_pkg::CH_W-1:0]       denom_o,
  output logic [hsl_pkg::NUM_W-1:0]      num_o
);

  localparam logic signed [18:0] C60  = 19'sd60;
  localparam logic signed [18:0] C120 = 19'sd120;
  localparam logic signed [18:0] C240 = 19'sd240;
  localparam logic signed [18:0] C360 = 19'sd360;

  logic [hsl_pkg::CH_W-1:0]  mx, mn, delta, denom;
  logic [hsl_pkg::CH_W:0]    sum, wrap;
  logic signed [18:0]        rs, gs, bs, ds, numv;

  logic                      valid_q, grey_q;
  logic [hsl_pkg::CH_W-1:0]  delta_q, denom_q;
  logic [hsl_pkg::NUM_W-1:0] num_q;

  // Find extremes, saturation divisor and hue dividend
  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    wrap  = 9'd510 - sum;
    denom = (sum <= 9'd255) ? sum[7:0] : wrap[7:0];
    rs = $signed({11'b0, red_i});
    gs = $signed({11'b0, green_i});
    bs = $signed({11'b0, blue_i});
    ds = $signed({11'b0, delta});
    if (red_i == mx) begin
      numv = C60 * (gs - bs);
      if (numv < 0) numv = numv + C360 * ds;
    end else if (green_i == mx) begin
      numv = C120 * ds + C60 * (bs - rs);
    end else begin
      numv = C240 * ds + C60 * (rs - gs);
    end
  end

  // Advance the stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      grey_q  <= (delta == '0);
      delta_q <= delta;
      denom_q <= denom;
      num_q   <= numv[hsl_pkg::NUM_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign grey_o  = grey_q;
  assign delta_o = delta_q;
  assign denom_o = denom_q;
  assign num_o   = num_q;

endmodule

>>> hw/rtl/hsl_div_pipe.sv
// Pipelined restoring dividers: saturation (one quotient bit per stage) and
// hue (nine bits in the last stages). Depends on hsl_pkg.
module hsl_div_pipe #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic                      grey_i,
  input  logic [hsl_pkg::CH_W-1:0]  delta_i,
  input  logic [hsl_pkg::CH_W-1:0]  denom_i,
  input  logic [hsl_pkg::NUM_W-1:0] num_i,
  output logic                      valid_o,
  output logic                      grey_o,
  output logic [FRAC_BITS:0]        sat_o,
  output logic [hsl_pkg::HUE_W-1:0] hue_o
);

  localparam int unsigned SW = FRAC_BITS + 1;
  localparam int unsigned NS = SW;
  localparam int unsigned HS = NS - hsl_pkg::HUE_W;
  localparam int unsigned CW = hsl_pkg::CH_W;
  localparam int unsigned HW = hsl_pkg::HUE_W;

  logic          vld_q [NS];
  logic          gr_q  [NS];
  logic [CW-1:0] sr_q  [NS];
  logic [CW-1:0] sr_d  [NS];
  logic [SW-1:0] sn_q  [NS];
  logic [SW-1:0] sn_d  [NS];
  logic [SW-1:0] sq_q  [NS];
  logic [SW-1:0] sq_d  [NS];
  logic [CW-1:0] sd_q  [NS];
  logic [CW-1:0] hr_q  [NS];
  logic [CW-1:0] hr_d  [NS];
  logic [HW-1:0] hn_q  [NS];
  logic [HW-1:0] hn_d  [NS];
  logic [HW-1:0] hq_q  [NS];
  logic [HW-1:0] hq_d  [NS];
  logic [CW-1:0] hd_q  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic          v_in, gr_in;
    logic [CW-1:0] sr_in, sd_in, hr_in, hd_in;
    logic [SW-1:0] sn_in, sq_in;
    logic [HW-1:0] hn_in, hq_in;
    logic [CW:0]   s_rem2, s_sub;
    logic          s_ge;

    // Select the stage input: preload at the head, previous stage after
    if (j == 0) begin : g_head
      assign v_in  = valid_i;
      assign gr_in = grey_i;
      assign sr_in = {1'b0, delta_i[CW-1:1]};
      assign sn_in = {delta_i[0], {FRAC_BITS{1'b0}}};
      assign sq_in = '0;
      assign sd_in = denom_i;
      assign hr_in = num_i[hsl_pkg::NUM_W-1:HW];
      assign hn_in = num_i[HW-1:0];
      assign hq_in = '0;
      assign hd_in = delta_i;
    end else begin : g_body
      assign v_in  = vld_q[j-1];
      assign gr_in = gr_q[j-1];
      assign sr_in = sr_q[j-1];
      assign sn_in = sn_q[j-1];
      assign sq_in = sq_q[j-1];
      assign sd_in = sd_q[j-1];
      assign hr_in = hr_q[j-1];
      assign hn_in = hn_q[j-1];
      assign hq_in = hq_q[j-1];
      assign hd_in = hd_q[j-1];
    end

    // Saturation step: shift in one dividend bit, subtract if it fits
    assign s_rem2  = {sr_in, sn_in[SW-1]};
    assign s_sub   = s_rem2 - {1'b0, sd_in};
    assign s_ge    = (s_rem2 >= {1'b0, sd_in});
    assign sr_d[j] = s_ge ? s_sub[CW-1:0] : s_rem2[CW-1:0];
    assign sn_d[j] = {sn_in[SW-2:0], 1'b0};
    assign sq_d[j] = {sq_in[SW-2:0], s_ge};

    // Hue step in the last stages, pass-through before
    if (j >= HS) begin : g_hue
      logic [CW:0] h_rem2, h_sub;
      logic        h_ge;
      assign h_rem2  = {hr_in, hn_in[HW-1]};
      assign h_sub   = h_rem2 - {1'b0, hd_in};
      assign h_ge    = (h_rem2 >= {1'b0, hd_in});
      assign hr_d[j] = h_ge ? h_sub[CW-1:0] : h_rem2[CW-1:0];
      assign hn_d[j] = {hn_in[HW-2:0], 1'b0};
      assign hq_d[j] = {hq_in[HW-2:0], h_ge};
    end else begin : g_hold
      assign hr_d[j] = hr_in;
      assign hn_d[j] = hn_in;
      assign hq_d[j] = hq_in;
    end

    // Advance the stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (adv_i) begin
        vld_q[j] <= v_in;
      end
    end

    // Capture the stage payload
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        gr_q[j] <= gr_in;
        sr_q[j] <= sr_d[j];
        sn_q[j] <= sn_d[j];
        sq_q[j] <= sq_d[j];
        sd_q[j] <= sd_in;
        hr_q[j] <= hr_d[j];
        hn_q[j] <= hn_d[j];
        hq_q[j] <= hq_d[j];
        hd_q[j] <= hd_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign grey_o  = gr_q[NS-1];
  assign sat_o   = sq_q[NS-1];
  assign hue_o   = hq_q[NS-1];

endmodule

>>> hw/rtl/hsl_back.sv
// Back end: HSL to RGB with the new lightness, six register stages ending in
// the output register. Depends on hsl_pkg.
module hsl_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic                      grey_i,
  input  logic [FRAC_BITS:0]        sat_i,
  input  logic [hsl_pkg::HUE_W-1:0] hue_i,
  input  logic [FRAC_BITS:0]        light_i,
  output logic                      valid_o,
  output logic [hsl_pkg::CH_W-1:0]  red_o,
  output logic [hsl_pkg::CH_W-1:0]  green_o,
  output logic [hsl_pkg::CH_W-1:0]  blue_o
);

  localparam int unsigned SW = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * SW;
  localparam int unsigned VW = SW + 1;
  localparam int unsigned MW = FRAC_BITS + 7;
  localparam int unsigned RW = MW - 5;
  localparam int unsigned CP = VW + 8;
  localparam int unsigned NC = hsl_pkg::CH_N;
  localparam int unsigned KW = hsl_pkg::K_W;
  localparam int unsigned CW = hsl_pkg::CH_W;
  localparam logic [63:0]    RECIP_FULL = (64'd1 << MW) / 64'd60;
  localparam logic [RW-1:0]  RECIP      = RECIP_FULL[RW-1:0];
  localparam logic [SW-1:0]  HALF       = SW'(1) << (FRAC_BITS - 1);
  localparam logic [MW-1:0]  SIXTY      = MW'(60);
  localparam logic [CP-1:0]  SCALE      = CP'(255);

  // Stage 1: lightness times saturation, ramp positions
  logic                    p1_vld_q, p1_grey_q;
  logic [SW-1:0]           p1_sat_q;
  logic [PW-1:0]           p1_prod_q;
  logic [KW-1:0]           p1_k_q [NC];
  logic [KW-1:0]           p1_k_d [NC];
  logic [hsl_pkg::DEG_W-1:0] hue_ext;

  // Stage 2: ramp ends
  logic                    p2_vld_q, p2_grey_q;
  logic [SW-1:0]           p2_v1_q;
  logic [VW-1:0]           p2_diff_q;
  logic [KW-1:0]           p2_k_q [NC];
  logic [SW-1:0]           ps;
  logic [VW-1:0]           v2, v1_full, diff;

  // Stage 3: ramp products
  logic                    p3_vld_q, p3_grey_q;
  logic [SW-1:0]           p3_v1_q;
  logic [MW-1:0]           p3_m_q [NC];

  // Stage 4: reciprocal estimate of the product over sixty
  logic                    p4_vld_q, p4_grey_q;
  logic [SW-1:0]           p4_v1_q;
  logic [MW-1:0]           p4_m_q [NC];
  logic [RW-1:0]           p4_e_q [NC];
  logic [MW+RW-1:0]        eprod  [NC];

  // Stage 5: corrected quotient plus low ramp end
  logic                    p5_vld_q;
  logic [VW-1:0]           p5_val_q [NC];
  logic [VW-1:0]           p5_val_d [NC];
  logic [MW-1:0]           rem      [NC];
  logic [RW-1:0]           quo      [NC];

  // Stage 6: output register
  logic                    out_vld_q;
  logic [CW-1:0]           out_ch_q [NC];
  logic [CW-1:0]           out_ch_d [NC];
  logic [CP-1:0]           cprod    [NC];
  logic [CP-FRAC_BITS-1:0] cshift   [NC];

  // Advance all stage valids together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      p1_vld_q  <= valid_i;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
      p4_vld_q  <= p3_vld_q;
      p5_vld_q  <= p4_vld_q;
      out_vld_q <= p5_vld_q;
    end
  end

  // Ramp positions for red, green and blue hue offsets
  assign hue_ext = hsl_pkg::DEG_W'(hue_i);
  assign p1_k_d[0] = hsl_pkg::ramp_k(hue_ext + hsl_pkg::DEG_120);
  assign p1_k_d[1] = hsl_pkg::ramp_k(hue_ext);
  assign p1_k_d[2] = hsl_pkg::ramp_k(hue_ext + hsl_pkg::DEG_240);

  // Upper and lower ramp ends
  always_comb begin
    ps = p1_prod_q[FRAC_BITS+SW-1:FRAC_BITS];
    if (light_i < HALF) begin
      v2 = {1'b0, light_i} + {1'b0, ps};
    end else begin
      v2 = {1'b0, light_i} + {1'b0, p1_sat_q} - {1'b0, ps};
    end
    v1_full = {light_i, 1'b0} - v2;
    diff    = v2 - {1'b0, v1_full[SW-1:0]};
  end

  // Per-channel division by sixty and channel scaling
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      eprod[c]    = (MW+RW)'(p3_m_q[c]) * (MW+RW)'(RECIP);
      rem[c]      = p4_m_q[c] - MW'(p4_e_q[c]) * SIXTY;
      quo[c]      = (rem[c] >= SIXTY) ? p4_e_q[c] + RW'(1) : p4_e_q[c];
      p5_val_d[c] = p4_grey_q ? {1'b0, light_i} : {1'b0, p4_v1_q} + VW'(quo[c]);
      cprod[c]    = CP'(p5_val_q[c]) * SCALE;
      cshift[c]   = cprod[c][CP-1:FRAC_BITS];
      out_ch_d[c] = (cshift[c] > (CP-FRAC_BITS)'(255)) ? 8'hFF : cshift[c][CW-1:0];
    end
  end

  // Capture stage payloads
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_grey_q <= grey_i;
      p1_sat_q  <= sat_i;
      p1_prod_q <= PW'(light_i) * PW'(sat_i);
      p2_grey_q <= p1_grey_q;
      p2_v1_q   <= v1_full[SW-1:0];
      p2_diff_q <= diff;
      p3_grey_q <= p2_grey_q;
      p3_v1_q   <= p2_v1_q;
      p4_grey_q <= p3_grey_q;
      p4_v1_q   <= p3_v1_q;
      for (int c = 0; c < NC; c++) begin
        p1_k_q[c]   <= p1_k_d[c];
        p2_k_q[c]   <= p1_k_q[c];
        p3_m_q[c]   <= MW'(p2_diff_q) * MW'(p2_k_q[c]);
        p4_m_q[c]   <= p3_m_q[c];
        p4_e_q[c]   <= eprod[c][MW+RW-1:MW];
        p5_val_q[c] <= p5_val_d[c];
        out_ch_q[c] <= out_ch_d[c];
      end
    end
  end

  assign valid_o = out_vld_q;
  assign red_o   = out_ch_q[0];
  assign green_o = out_ch_q[1];
  assign blue_o  = out_ch_q[2];

endmodule

>>> hw/rtl/hsl_lightness_set_unit.sv
// HSL lightness set unit: replaces the HSL lightness of each RGB pixel.
// Input pixels arrive on in_valid_i / in_stall_o with in_red_i, in_green_i
// and in_blue_i; a transfer happens when valid is high and stall is low.
// Results leave on out_valid_o / out_stall_i with out_red_o, out_green_o and
// out_blue_o, one result per pixel, in order.
// The target lightness (65536 = 1.0, larger values saturate) is written on
// cfg_valid_i / cfg_ready_o with cfg_data_i; ready is always high. Write it
// only while no pixel is in flight.
// The pipeline has one input stage, FRAC_BITS + 1 stages of the saturation
// divider, one quotient bit per stage, and six back-end stages ending in the
// output register.
// Throughput is one pixel per cycle unless out_stall_i holds a result; then
// the whole pipeline freezes and in_stall_o is high; nothing is lost.
// Reset clears all stage valids and sets the target lightness to 0.5.
// Depends on hsl_pkg, hsl_front, hsl_div_pipe and hsl_back.
module hsl_lightness_set_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [hsl_pkg::CH_W-1:0]  in_red_i,
  input  logic [hsl_pkg::CH_W-1:0]  in_green_i,
  input  logic [hsl_pkg::CH_W-1:0]  in_blue_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [hsl_pkg::CH_W-1:0]  out_red_o,
  output logic [hsl_pkg::CH_W-1:0]  out_green_o,
  output logic [hsl_pkg::CH_W-1:0]  out_blue_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hsl_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int unsigned SW = FRAC_BITS + 1;

  logic [hsl_pkg::CFG_W-1:0]  cfg_q, cfg_sat;
  logic [SW-1:0]              light;
  logic                       adv;
  logic                       fr_valid, fr_grey;
  logic [hsl_pkg::CH_W-1:0]   fr_delta, fr_denom;
  logic [hsl_pkg::NUM_W-1:0]  fr_num;
  logic                       dv_valid, dv_grey;
  logic [SW-1:0]              dv_sat;
  logic [hsl_pkg::HUE_W-1:0]  dv_hue;

  // Hold the target lightness register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hsl_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Saturate to 1.0 and rescale to the internal fraction width
  assign cfg_sat = (cfg_q > hsl_pkg::CFG_ONE) ? hsl_pkg::CFG_ONE : cfg_q;
  if (FRAC_BITS >= hsl_pkg::CFG_FRAC) begin : g_widen
    assign light = SW'(cfg_sat) << (FRAC_BITS - hsl_pkg::CFG_FRAC);
  end else begin : g_narrow
    assign light = SW'(cfg_sat >> (hsl_pkg::CFG_FRAC - FRAC_BITS));
  end

  // Freeze every stage while the output register is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  hsl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .red_i   (in_red_i),
    .green_i (in_green_i),
    .blue_i  (in_blue_i),
    .valid_o (fr_valid),
    .grey_o  (fr_grey),
    .delta_o (fr_delta),
    .denom_o (fr_denom),
    .num_o   (fr_num)
  );

  hsl_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_valid),
    .grey_i  (fr_grey),
    .delta_i (fr_delta),
    .denom_i (fr_denom),
    .num_i   (fr_num),
    .valid_o (dv_valid),
    .grey_o  (dv_grey),
    .sat_o   (dv_sat),
    .hue_o   (dv_hue)
  );

  hsl_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_valid),
    .grey_i  (dv_grey),
    .sat_i   (dv_sat),
    .hue_i   (dv_hue),
    .light_i (light),
    .valid_o (out_valid_o),
    .red_o   (out_red_o),
    .green_o (out_green_o),
    .blue_o  (out_blue_o)
  );

endmodule
